/* hdl/mthp_pkg.sv */
// shared types, constants and helpers for the model tensor header parser
// no dependencies

package mthp_pkg;

    localparam logic [31:0] MAGIC_WORD = 32'h4655_4747;

    localparam logic [31:0] VT_STRING = 32'd8;
    localparam logic [31:0] VT_ARRAY  = 32'd9;

    localparam logic [1:0] KIND_TENSOR = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        PH_MAGIC, PH_VERSION, PH_NTENS, PH_NKV, PH_KEYLEN, PH_KEYSKIP, PH_VTYPE,
        PH_VALSKIP, PH_STRLEN, PH_ATYPE, PH_ALEN, PH_ASTRLEN, PH_ELEMSKIP,
        PH_NAMELEN, PH_NAMESKIP, PH_NDIMS, PH_DIM, PH_DTYPE, PH_OFFSET, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tensor_number;
        logic [31:0] element_type;
        logic [63:0] position;
        logic [63:0] element_count;
        logic        beyond;
        logic        last;
    } rec_t;

    function automatic logic [3:0] value_size(input logic [31:0] t, input logic [3:0] unknown);
        logic [3:0] r;
        r = unknown;
        if (t == 32'd0 || t == 32'd1 || t == 32'd7)
            r = 4'd1;
        else if (t == 32'd2 || t == 32'd3)
            r = 4'd2;
        else if (t == 32'd4 || t == 32'd5 || t == 32'd6)
            r = 4'd4;
        else if (t == 32'd10 || t == 32'd11 || t == 32'd12)
            r = 4'd8;
        return r;
    endfunction

endpackage

/* hdl/mthp_front.sv */
// front part: byte-wise header parse, field assembly, record generation
// depends on mthp_pkg

module mthp_front
    import mthp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        in_sof,
    input  logic [63:0] file_size,
    output logic [1:0]  push_cnt,
    output rec_t        rec0,
    output rec_t        rec1
);

    phase_t      phase_reg, phase_next, ph;
    logic [63:0] pos_reg, pos_cur;
    logic [63:0] acc_reg, acc_next, acc_cur;
    logic [2:0]  cnt_reg, cnt_next, cnt_cur;
    logic [63:0] skip_reg, skip_next, skip_cur;
    logic [63:0] pairs_reg, pairs_next, pairs_cur;
    logic [63:0] tens_reg, tens_next, tens_cur;
    logic [31:0] tnum_reg, tnum_next, tnum_cur;
    logic [2:0]  didx_reg, didx_next, didx_cur;
    logic        astr_reg, astr_next, astr_cur;
    logic [3:0]  asize_reg, asize_next, asize_cur;
    logic [63:0] arem_reg, arem_next, arem_cur;
    logic [31:0] dims_reg, dims_next, dims_cur;
    logic [63:0] ec_reg, ec_next, ec_cur;
    logic [63:0] prod_reg, prod_next, prod_cur;
    logic [31:0] ctype_reg, ctype_next, ctype_cur;

    logic [63:0] v;
    logic [3:0]  n_cnt;
    logic        done;
    logic [71:0] mul_full;
    logic [63:0] term;
    logic        f_next_elem, f_end_pair, f_begin;
    logic        em_tensor, em_data, em_bad, beyond;
    logic [63:0] data_pos;

    always_comb
    begin
        ph        = in_sof ? PH_MAGIC : phase_reg;
        pos_cur   = in_sof ? 64'd0 : pos_reg;
        acc_cur   = in_sof ? 64'd0 : acc_reg;
        cnt_cur   = in_sof ? 3'd0 : cnt_reg;
        skip_cur  = in_sof ? 64'd0 : skip_reg;
        pairs_cur = in_sof ? 64'd0 : pairs_reg;
        tens_cur  = in_sof ? 64'd0 : tens_reg;
        tnum_cur  = in_sof ? 32'd0 : tnum_reg;
        didx_cur  = in_sof ? 3'd0 : didx_reg;
        astr_cur  = in_sof ? 1'b0 : astr_reg;
        asize_cur = in_sof ? 4'd0 : asize_reg;
        arem_cur  = in_sof ? 64'd0 : arem_reg;
        dims_cur  = in_sof ? 32'd0 : dims_reg;
        ec_cur    = in_sof ? 64'd1 : ec_reg;
        prod_cur  = in_sof ? 64'd0 : prod_reg;
        ctype_cur = in_sof ? 32'd0 : ctype_reg;

        phase_next = ph;
        acc_next   = acc_cur;
        cnt_next   = cnt_cur;
        skip_next  = skip_cur;
        pairs_next = pairs_cur;
        tens_next  = tens_cur;
        tnum_next  = tnum_cur;
        didx_next  = didx_cur;
        astr_next  = astr_cur;
        asize_next = asize_cur;
        arem_next  = arem_cur;
        dims_next  = dims_cur;
        ec_next    = ec_cur;
        prod_next  = prod_cur;
        ctype_next = ctype_cur;

        f_next_elem = 1'b0;
        f_end_pair  = 1'b0;
        f_begin     = 1'b0;
        em_tensor   = 1'b0;
        em_data     = 1'b0;
        em_bad      = 1'b0;

        v        = acc_cur | (64'(in_byte) << {cnt_cur, 3'b000});
        n_cnt    = {1'b0, cnt_cur} + 4'd1;
        mul_full = 72'(ec_cur) * 72'(in_byte);
        term     = mul_full[63:0] << {cnt_cur, 3'b000};
        beyond   = v >= file_size;
        data_pos = (pos_cur + 64'd32) & ~64'd31;

        if (ph == PH_MAGIC || ph == PH_VERSION || ph == PH_VTYPE || ph == PH_ATYPE
            || ph == PH_NDIMS || ph == PH_DTYPE)
            done = n_cnt >= 4'd4;
        else
            done = n_cnt >= 4'd8;

        if (ph == PH_DONE)
        begin
            done = 1'b0;
        end
        else if (ph == PH_KEYSKIP || ph == PH_VALSKIP || ph == PH_ELEMSKIP
                 || ph == PH_NAMESKIP)
        begin
            done      = 1'b0;
            skip_next = skip_cur - 64'd1;
            if (skip_next == 64'd0)
            begin
                unique case (ph)
                    PH_KEYSKIP:  phase_next = PH_VTYPE;
                    PH_VALSKIP:  f_end_pair = 1'b1;
                    PH_ELEMSKIP: f_next_elem = 1'b1;
                    default:     phase_next = PH_NDIMS;
                endcase
            end
        end
        else
        begin
            if (ph == PH_DIM && didx_cur < 3'd4)
                prod_next = prod_cur + term;
            if (!done)
            begin
                acc_next = v;
                cnt_next = n_cnt[2:0];
            end
            else
            begin
                acc_next = 64'd0;
                cnt_next = 3'd0;
            end
        end

        if (done)
        begin
            unique case (ph)
                PH_MAGIC:
                begin
                    if (v[31:0] != MAGIC_WORD)
                    begin
                        em_bad     = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                        phase_next = PH_VERSION;
                end
                PH_VERSION: phase_next = PH_NTENS;
                PH_NTENS:
                begin
                    tens_next  = v;
                    phase_next = PH_NKV;
                end
                PH_NKV:
                begin
                    pairs_next = v;
                    if (v == 64'd0)
                        f_begin = 1'b1;
                    else
                        phase_next = PH_KEYLEN;
                end
                PH_KEYLEN:
                begin
                    skip_next  = v;
                    phase_next = (v == 64'd0) ? PH_VTYPE : PH_KEYSKIP;
                end
                PH_VTYPE:
                begin
                    if (v[31:0] == VT_STRING)
                        phase_next = PH_STRLEN;
                    else if (v[31:0] == VT_ARRAY)
                        phase_next = PH_ATYPE;
                    else
                    begin
                        skip_next  = 64'(value_size(v[31:0], 4'd8));
                        phase_next = PH_VALSKIP;
                    end
                end
                PH_STRLEN:
                begin
                    skip_next = v;
                    if (v == 64'd0)
                        f_end_pair = 1'b1;
                    else
                        phase_next = PH_VALSKIP;
                end
                PH_ATYPE:
                begin
                    astr_next  = v[31:0] == VT_STRING;
                    asize_next = value_size(v[31:0], 4'd4);
                    phase_next = PH_ALEN;
                end
                PH_ALEN:
                begin
                    arem_next   = v;
                    f_next_elem = 1'b1;
                end
                PH_ASTRLEN:
                begin
                    skip_next = v;
                    if (v == 64'd0)
                        f_next_elem = 1'b1;
                    else
                        phase_next = PH_ELEMSKIP;
                end
                PH_NAMELEN:
                begin
                    skip_next  = v;
                    phase_next = (v == 64'd0) ? PH_NDIMS : PH_NAMESKIP;
                end
                PH_NDIMS:
                begin
                    dims_next  = v[31:0];
                    didx_next  = 3'd0;
                    ec_next    = 64'd1;
                    prod_next  = 64'd0;
                    phase_next = (v[31:0] != 32'd0) ? PH_DIM : PH_DTYPE;
                end
                PH_DIM:
                begin
                    if (didx_cur < 3'd4)
                    begin
                        ec_next   = prod_cur + term;
                        didx_next = didx_cur + 3'd1;
                    end
                    prod_next = 64'd0;
                    dims_next = dims_cur - 32'd1;
                    if (dims_next == 32'd0)
                        phase_next = PH_DTYPE;
                end
                PH_DTYPE:
                begin
                    ctype_next = v[31:0];
                    phase_next = PH_OFFSET;
                end
                PH_OFFSET:
                begin
                    em_tensor = 1'b1;
                    tnum_next = tnum_cur + 32'd1;
                    tens_next = tens_cur - 64'd1;
                    f_begin   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (f_next_elem)
        begin
            if (arem_next == 64'd0)
                f_end_pair = 1'b1;
            else
            begin
                arem_next = arem_next - 64'd1;
                if (astr_next)
                    phase_next = PH_ASTRLEN;
                else
                begin
                    skip_next  = 64'(asize_next);
                    phase_next = PH_ELEMSKIP;
                end
            end
        end

        if (f_end_pair)
        begin
            pairs_next = pairs_next - 64'd1;
            if (pairs_next == 64'd0)
                f_begin = 1'b1;
            else
                phase_next = PH_KEYLEN;
        end

        if (f_begin)
        begin
            if (tens_next == 64'd0)
            begin
                em_data    = 1'b1;
                phase_next = PH_DONE;
            end
            else
                phase_next = PH_NAMELEN;
        end
    end

    always_comb
    begin
        rec0 = '0;
        rec1 = '0;
        rec1.kind     = KIND_DATA;
        rec1.position = data_pos;
        rec1.last     = 1'b1;
        if (em_tensor)
        begin
            rec0.kind          = KIND_TENSOR;
            rec0.tensor_number = tnum_cur;
            rec0.element_type  = ctype_cur;
            rec0.position      = v;
            rec0.element_count = ec_cur;
            rec0.beyond        = beyond;
        end
        else if (em_bad)
        begin
            rec0.kind = KIND_BAD;
            rec0.last = 1'b1;
        end
        else
            rec0 = rec1;
        if (!step)
            push_cnt = 2'd0;
        else
            push_cnt = 2'({1'b0, em_tensor} + {1'b0, em_data} + {1'b0, em_bad});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            skip_reg  <= '0;
            pairs_reg <= '0;
            tens_reg  <= '0;
            tnum_reg  <= '0;
            didx_reg  <= '0;
            astr_reg  <= 1'b0;
            asize_reg <= '0;
            arem_reg  <= '0;
            dims_reg  <= '0;
            ec_reg    <= 64'd1;
            prod_reg  <= '0;
            ctype_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_cur + 64'd1;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            pairs_reg <= pairs_next;
            tens_reg  <= tens_next;
            tnum_reg  <= tnum_next;
            didx_reg  <= didx_next;
            astr_reg  <= astr_next;
            asize_reg <= asize_next;
            arem_reg  <= arem_next;
            dims_reg  <= dims_next;
            ec_reg    <= ec_next;
            prod_reg  <= prod_next;
            ctype_reg <= ctype_next;
        end
    end

endmodule

/* hdl/mthp_queue.sv */
// record queue between front and back, up to two writes and one read per cycle
// depends on mthp_pkg

module mthp_queue
    import mthp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  rec_t       rec0,
    input  rec_t       rec1,
    input  logic       pop,
    output logic       can_take,
    output logic       not_empty,
    output rec_t       head
);

    rec_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW-1:0] wr_plus;

    assign wr_plus   = wr_reg + 1'b1;
    assign not_empty = count_reg != '0;
    assign can_take  = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
    assign head      = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_reg] <= rec0;
        if (push_cnt == 2'd2)
            mem[wr_plus] <= rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + QUEUE_AW'(push_cnt);
            rd_reg    <= rd_reg + QUEUE_AW'(pop);
            count_reg <= count_reg + (QUEUE_AW+1)'(push_cnt) - (QUEUE_AW+1)'(pop);
        end
    end

endmodule

/* hdl/mthp_back.sv */
// back part: byte size from element count and type, output register
// depends on mthp_pkg

module mthp_back
    import mthp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         not_empty,
    input  rec_t         head,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    logic         valid_reg;
    logic [191:0] data_reg, data_next;
    logic [2:0]   user_reg;
    logic         last_reg;
    logic [63:0]  n, b32, b256, size;

    assign pop = not_empty && (!valid_reg || m_tready);

    always_comb
    begin
        n    = head.element_count;
        b32  = (n >> 5) + 64'(n[4:0] != 5'd0);
        b256 = (n >> 8) + 64'(n[7:0] != 8'd0);
        unique case (head.element_type)
            32'd0:          size = n << 2;
            32'd2:          size = (b32 << 4) + (b32 << 1);
            32'd3:          size = (b32 << 4) + (b32 << 2);
            32'd6, 32'd39, 32'd47:
                            size = (b32 << 5) + (b32 << 1);
            32'd12:         size = (b256 << 7) + (b256 << 4);
            32'd14:         size = (b256 << 8) - (b256 << 4);
            default:        size = n << 1;
        endcase
        if (head.beyond || head.kind != KIND_TENSOR)
            size = 64'd0;
        data_next = {size, head.position, head.element_type, head.tensor_number};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            user_reg <= {head.beyond, head.kind};
            last_reg <= head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* hdl/model_tensor_header_parser.sv */
// top level: parses a model file header one byte per cycle into tensor records
// a completed record passes through the record queue and then the output register
// throughput: one byte per cycle; input stalls only while the record queue
// has fewer than two free slots
// reset: rst_n asynchronous, resets parse state and clears file_size to zero
// depends on mthp_pkg, mthp_front, mthp_queue, mthp_back

module model_tensor_header_parser
    import mthp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         file_size_we,
    input  logic [63:0]  file_size_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // header_byte
    input  logic [0:0]   s_tuser,   // start_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // tensor_number, element_type, position_value, byte_size
    output logic [2:0]   m_tuser,   // record_kind[1:0], offset_beyond_file
    output logic         m_tlast    // last_record
);

    logic [63:0] file_size_reg;
    logic        step, pop, not_empty;
    logic [1:0]  push_cnt;
    rec_t        rec0, rec1, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_size_reg <= '0;
        else if (file_size_we)
            file_size_reg <= file_size_wdata;
    end

    assign step = s_tvalid && s_tready;

    mthp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (s_tdata),
        .in_sof    (s_tuser[0]),
        .file_size (file_size_reg),
        .push_cnt  (push_cnt),
        .rec0      (rec0),
        .rec1      (rec1)
    );

    mthp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .rec0      (rec0),
        .rec1      (rec1),
        .pop       (pop),
        .can_take  (s_tready),
        .not_empty (not_empty),
        .head      (head)
    );

    mthp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* hdl/mthp_checker.sv */
// port-level checks for model_tensor_header_parser and the bind that attaches them
// depends on mthp_pkg

module mthp_checker
    import mthp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] != KIND_TENSOR)))
        else $error("last marker does not match record kind");

    a_beyond: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[191:128] == 64'd0 && m_tuser[1:0] == KIND_TENSOR)
        else $error("skipped tensor carries a size");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != KIND_TENSOR |->
            m_tdata[63:0] == 64'd0 && m_tdata[191:128] == 64'd0
            && m_tuser[1:0] != 2'd3)
        else $error("non-tensor record has tensor fields");

endmodule

bind model_tensor_header_parser mthp_checker u_mthp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/model_tensor_header_parser_check.sv */
// checker for the model tensor header parser: predicts records from accepted
// header bytes and compares them with the record stream; depends on mthp_pkg
`timescale 1ns / 1ps

module model_tensor_header_parser_check
    import mthp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         file_size_we,
    input  logic [63:0]  file_size_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           fails,
    output int           pending
);

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] num;
        logic [31:0] etype;
        logic [63:0] pos;
        logic [63:0] size;
        logic        beyond;
        logic        last;
    } record_t;

    record_t     records_due[$];
    int          step_count;

    logic [63:0] fsize;
    phase_t      ph;
    logic [63:0] bpos, acc, skip_left, pairs_left, tens_left, arr_left, elems;
    logic [3:0]  acc_bytes;
    logic [31:0] tens_idx, vkind, akind, dims_left, ctype;

    assign pending = records_due.size();

    function void put_record(logic [1:0] k, logic [31:0] n, logic [31:0] t,
                             logic [63:0] p, logic [63:0] s, logic b, logic l);
        record_t r;
        if (step_count < 2)
        begin
            r = '{k, n, t, p, s, b, l};
            records_due.push_back(r);
            step_count++;
        end
    endfunction

    function void payload_start();
        logic [63:0] e;
        e = bpos + 64'd1 + 64'd31;
        put_record(KIND_DATA, 0, 0, {e[63:5], 5'd0}, 0, 1'b0, 1'b1);
        ph = PH_DONE;
    endfunction

    function void tensors_next();
        if (tens_left == 0)
            payload_start();
        else
            ph = PH_NAMELEN;
    endfunction

    function void pair_done();
        pairs_left = pairs_left - 1;
        if (pairs_left == 0)
            tensors_next();
        else
            ph = PH_KEYLEN;
    endfunction

    function logic [63:0] scalar_bytes(logic [31:0] t, logic [63:0] unk);
        case (t)
            0, 1, 7:    return 1;
            2, 3:       return 2;
            4, 5, 6:    return 4;
            10, 11, 12: return 8;
            default:    return unk;
        endcase
    endfunction

    function void elem_next();
        if (arr_left == 0)
        begin
            pair_done();
            return;
        end
        arr_left = arr_left - 1;
        if (akind == VT_STRING)
            ph = PH_ASTRLEN;
        else
        begin
            skip_left = scalar_bytes(akind, 4);
            ph = PH_ELEMSKIP;
        end
    endfunction

    function void skip_end(phase_t p);
        if (p == PH_KEYSKIP)
            ph = PH_VTYPE;
        else if (p == PH_VALSKIP)
            pair_done();
        else if (p == PH_ELEMSKIP)
            elem_next();
        else
            ph = PH_NDIMS;
    endfunction

    function void skip_begin(logic [63:0] n, phase_t p);
        if (n == 0)
            skip_end(p);
        else
        begin
            skip_left = n;
            ph = p;
        end
    endfunction

    function logic [63:0] block_count(logic [63:0] n, int sh);
        logic [63:0] m;
        m = (64'd1 << sh) - 1;
        return (n >> sh) + (((n & m) != 0) ? 64'd1 : 64'd0);
    endfunction

    function logic [63:0] payload_bytes();
        case (ctype)
            0:         return elems * 4;
            2:         return block_count(elems, 5) * 18;
            3:         return block_count(elems, 5) * 20;
            6, 39, 47: return block_count(elems, 5) * 34;
            12:        return block_count(elems, 8) * 144;
            14:        return block_count(elems, 8) * 240;
            default:   return elems * 2;
        endcase
    endfunction

    function void field_end(logic [63:0] v);
        logic b;
        case (ph)
            PH_MAGIC:
                if (v[31:0] != MAGIC_WORD)
                begin
                    put_record(KIND_BAD, 0, 0, 0, 0, 1'b0, 1'b1);
                    ph = PH_DONE;
                end
                else
                    ph = PH_VERSION;
            PH_VERSION: ph = PH_NTENS;
            PH_NTENS:
            begin
                tens_left = v;
                ph = PH_NKV;
            end
            PH_NKV:
            begin
                pairs_left = v;
                if (v == 0)
                    tensors_next();
                else
                    ph = PH_KEYLEN;
            end
            PH_KEYLEN: skip_begin(v, PH_KEYSKIP);
            PH_VTYPE:
            begin
                vkind = v[31:0];
                if (vkind == VT_STRING)
                    ph = PH_STRLEN;
                else if (vkind == VT_ARRAY)
                    ph = PH_ATYPE;
                else
                    skip_begin(scalar_bytes(vkind, 8), PH_VALSKIP);
            end
            PH_STRLEN: skip_begin(v, PH_VALSKIP);
            PH_ATYPE:
            begin
                akind = v[31:0];
                ph = PH_ALEN;
            end
            PH_ALEN:
            begin
                arr_left = v;
                elem_next();
            end
            PH_ASTRLEN: skip_begin(v, PH_ELEMSKIP);
            PH_NAMELEN: skip_begin(v, PH_NAMESKIP);
            PH_NDIMS:
            begin
                dims_left = v[31:0];
                vkind = 0;
                elems = 1;
                ph = (dims_left != 0) ? PH_DIM : PH_DTYPE;
            end
            PH_DIM:
            begin
                // only the first four dimensions count
                if (vkind < 4)
                begin
                    elems = elems * v;
                    vkind = vkind + 1;
                end
                dims_left = dims_left - 1;
                if (dims_left == 0)
                    ph = PH_DTYPE;
            end
            PH_DTYPE:
            begin
                ctype = v[31:0];
                ph = PH_OFFSET;
            end
            PH_OFFSET:
            begin
                b = (v >= fsize);
                put_record(KIND_TENSOR, tens_idx, ctype, v, b ? 64'd0 : payload_bytes(), b, 1'b0);
                tens_idx = tens_idx + 1;
                tens_left = tens_left - 1;
                tensors_next();
            end
            default: ;
        endcase
    endfunction

    function void restart();
        ph = PH_MAGIC;
        bpos = 0;
        acc = 0;
        acc_bytes = 0;
        skip_left = 0;
        pairs_left = 0;
        tens_left = 0;
        tens_idx = 0;
        vkind = 0;
        akind = 0;
        arr_left = 0;
        dims_left = 0;
        elems = 1;
        ctype = 0;
    endfunction

    function void take_byte(logic [7:0] b, logic sof);
        logic [63:0] v;
        step_count = 0;
        if (sof)
            restart();
        if (ph == PH_DONE)
        begin
            bpos = bpos + 1;
            return;
        end
        if (ph == PH_KEYSKIP || ph == PH_VALSKIP || ph == PH_ELEMSKIP || ph == PH_NAMESKIP)
        begin
            skip_left = skip_left - 1;
            if (skip_left == 0)
                skip_end(ph);
        end
        else
        begin
            acc = acc | (64'(b) << ({1'b0, acc_bytes[2:0]} * 8));
            acc_bytes = acc_bytes + 1;
            if (acc_bytes >= ((ph == PH_MAGIC || ph == PH_VERSION || ph == PH_VTYPE ||
                               ph == PH_ATYPE || ph == PH_NDIMS || ph == PH_DTYPE) ? 4 : 8))
            begin
                v = acc;
                acc = 0;
                acc_bytes = 0;
                field_end(v);
            end
        end
        bpos = bpos + 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        record_t r;
        if (!rst_n)
        begin
            fsize = 0;
            restart();
            records_due.delete();
            fails = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (records_due.size() == 0)
                begin
                    $error("record with none expected");
                    fails++;
                end
                else
                begin
                    r = records_due.pop_front();
                    if (m_tuser[1:0] !== r.kind)
                    begin
                        $error("record_kind exp %0d got %0d", r.kind, m_tuser[1:0]);
                        fails++;
                    end
                    if (m_tdata[31:0] !== r.num)
                    begin
                        $error("tensor_number exp %0d got %0d", r.num, m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[63:32] !== r.etype)
                    begin
                        $error("element_type exp %0d got %0d", r.etype, m_tdata[63:32]);
                        fails++;
                    end
                    if (m_tdata[127:64] !== r.pos)
                    begin
                        $error("position_value exp %h got %h", r.pos, m_tdata[127:64]);
                        fails++;
                    end
                    if (m_tdata[191:128] !== r.size)
                    begin
                        $error("byte_size exp %h got %h", r.size, m_tdata[191:128]);
                        fails++;
                    end
                    if (m_tuser[2] !== r.beyond)
                    begin
                        $error("offset_beyond_file exp %0d got %0d", r.beyond, m_tuser[2]);
                        fails++;
                    end
                    if (m_tlast !== r.last)
                    begin
                        $error("last_record exp %0d got %0d", r.last, m_tlast);
                        fails++;
                    end
                end
            end
            if (file_size_we)
                fsize = file_size_wdata;
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tuser[0]);
        end
    end

endmodule

/* tb/model_tensor_header_parser_test.sv */
// top of the model tensor header parser testbench: clock, reset, header stream
// stimulus and verdict; depends on mthp_pkg, the block and its checker
`timescale 1ns / 1ps

module model_tensor_header_parser_test;
    import mthp_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         file_size_we = 0;
    logic [63:0]  file_size_wdata = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic [0:0]   s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [191:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    int           fails, pending;
    int           src_idle, dst_idle;
    logic [63:0]  fsize;
    logic [7:0]   file_bytes[$];
    int           sent;

    model_tensor_header_parser dut (.*);
    model_tensor_header_parser_check check (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle);

    initial
    begin
        #50ms;
        $display("[model_tensor_header_parser] ERROR");
        $finish;
    end

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function void put_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function void put_junk(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back($urandom_range(255));
    endfunction

    function int scalar_len(logic [31:0] t, int unk);
        case (t)
            0, 1, 7:    return 1;
            2, 3:       return 2;
            4, 5, 6:    return 4;
            10, 11, 12: return 8;
            default:    return unk;
        endcase
    endfunction

    function logic [31:0] pick_vtype(int sel);
        if (sel < 14)
            return sel;
        return (sel == 14) ? $urandom : $urandom_range(13, 40);
    endfunction

    function logic [31:0] pick_dtype(int sel);
        logic [31:0] dt[10] = '{0, 1, 2, 3, 6, 12, 14, 30, 39, 47};
        return (sel < 10) ? dt[sel] : $urandom;
    endfunction

    function logic [63:0] pick_offset();
        case ($urandom_range(3))
            0: return rand64();
            1: return (fsize == 0) ? rand64() : fsize - 1;
            2: return fsize;
            default: return (fsize == 0) ? 64'd0 : rand64() % fsize;
        endcase
    endfunction

    function logic [63:0] pick_dim();
        case ($urandom_range(9))
            0: return rand64();
            1: return $urandom;
            2: return 0;
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    // one header; ordered selects walk value and element types in turn
    function void build_file(bit bad, int nt, int nkv, bit ordered, int ndmax);
        logic [31:0] vt, at;
        int n, len;
        file_bytes.delete();
        if (bad)
            put_le(MAGIC_WORD ^ (32'd1 << $urandom_range(31)), 4);
        else
            put_le(MAGIC_WORD, 4);
        put_le($urandom, 4);
        put_le(nt, 8);
        put_le(nkv, 8);
        for (int k = 0; k < nkv; k++)
        begin
            len = $urandom_range(0, 4);
            put_le(len, 8);
            put_junk(len);
            vt = pick_vtype(ordered ? k % 16 : $urandom_range(15));
            put_le(vt, 4);
            if (vt == VT_STRING)
            begin
                len = $urandom_range(0, 5);
                put_le(len, 8);
                put_junk(len);
            end
            else if (vt == VT_ARRAY)
            begin
                at = pick_vtype($urandom_range(15));
                n = $urandom_range(0, 4);
                put_le(at, 4);
                put_le(n, 8);
                for (int e = 0; e < n; e++)
                    if (at == VT_STRING)
                    begin
                        len = $urandom_range(0, 4);
                        put_le(len, 8);
                        put_junk(len);
                    end
                    else
                        put_junk(scalar_len(at, 4));
            end
            else
                put_junk(scalar_len(vt, 8));
        end
        for (int t = 0; t < nt; t++)
        begin
            len = $urandom_range(0, 5);
            put_le(len, 8);
            put_junk(len);
            n = $urandom_range(0, ndmax);
            put_le(n, 4);
            for (int d = 0; d < n; d++)
                put_le(pick_dim(), 8);
            put_le(pick_dtype(ordered ? t % 11 : $urandom_range(10)), 4);
            put_le(pick_offset(), 8);
        end
        put_junk($urandom_range(0, 3));
        // now and then a restart in mid-header
        if ($urandom_range(14) == 0)
            file_bytes = file_bytes[0 : $urandom_range(file_bytes.size() - 1)];
    endfunction

    task send_byte(logic [7:0] b, logic sof);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
        sent += file_bytes.size();
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task write_file_size(logic [63:0] v);
        drain();
        fsize = v;
        file_size_we <= 1'b1;
        file_size_wdata <= v;
        @(posedge clk);
        file_size_we <= 1'b0;
    endtask

    initial
    begin
        logic [63:0] sizes[9];
        sizes = '{64'd0, '1, 64'd4096, 64'd1, rand64(), 64'd100000, '1, rand64(), 64'd0};
        src_idle = 0;
        dst_idle = 0;
        fsize = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_file_size(64'd4096);
        build_file(1, 0, 0, 0, 0);
        send_file();
        build_file(0, 0, 0, 0, 0);
        send_file();
        build_file(0, 11, 16, 1, 6);
        send_file();
        build_file(0, 2, 0, 0, 6);
        send_file();

        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle = (mode == 0) ? 13 : (mode == 1) ? 58 : 0;
            dst_idle = (mode == 0) ? 58 : (mode == 1) ? 13 : 0;
            for (int sub = 0; sub < 3; sub++)
            begin
                write_file_size(sizes[3*mode + sub]);
                sent = 0;
                while (sent < 135)
                begin
                    build_file($urandom_range(11) == 0, $urandom_range(0, 4),
                               $urandom_range(0, 3), 0, 6);
                    send_file();
                end
            end
        end

        drain();
        if (fails == 0)
            $display("[model_tensor_header_parser] OK");
        else
            $display("[model_tensor_header_parser] ERROR");
        $finish;
    end

endmodule

/* model_tensor_header_parser.f */
hdl/mthp_pkg.sv
hdl/mthp_front.sv
hdl/mthp_queue.sv
hdl/mthp_back.sv
hdl/model_tensor_header_parser.sv
hdl/mthp_checker.sv
tb/model_tensor_header_parser_check.sv
tb/model_tensor_header_parser_test.sv
